[sv/rres_pkg.sv]
// ----------------------------------------------------------------------------
// rres_pkg
// Shared types and constants for the round-robin event scheduler.
// ----------------------------------------------------------------------------
package rres_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned IDX_W = 5;
  localparam int unsigned CNT_W = 6;
  localparam int unsigned SEC_W = 22;

  localparam logic [2:0] OP_LOAD     = 3'd0;
  localparam logic [2:0] OP_POLL     = 3'd1;
  localparam logic [2:0] OP_REPORT   = 3'd2;
  localparam logic [2:0] OP_ZAP      = 3'd3;
  localparam logic [2:0] OP_RESET    = 3'd4;
  localparam logic [2:0] OP_DONE     = 3'd5;
  localparam logic [2:0] OP_ALL_DONE = 3'd6;
  localparam logic [2:0] OP_SET_NEXT = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [4:0]  entry_index;
    logic [2:0]  entry_kind;
    logic [23:0] hour_mask;
    logic [6:0]  day_mask;
    logic [15:0] redo_minutes;
    logic [15:0] retry_minutes;
    logic [31:0] now_seconds;
    logic [4:0]  hour_of_day;
    logic [2:0]  weekday;
    logic        mark_success;
    logic        mark_try;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] chosen_index;
    logic [2:0] chosen_kind;
    logic [4:0] next_pointer;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic [2:0]       kind;
    logic [23:0]      hours;
    logic [6:0]       days;
    logic [SEC_W-1:0] redo_sec;
    logic [SEC_W-1:0] retry_sec;
    logic [31:0]      t_success;
    logic [31:0]      t_try;
  } entry_t;

  typedef struct packed {
    logic [2:0] op;
    logic       sel;
  } head_ctl_t;

endpackage

[sv/rres_cell.sv]
// ----------------------------------------------------------------------------
// rres_cell
// One table slot in the rotating ring; takes its neighbor's entry on shift.
// ----------------------------------------------------------------------------
module rres_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift,
  input  rres_pkg::entry_t d,
  output rres_pkg::entry_t q
);

  rres_pkg::entry_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid     <= 1'b0;
      q_r.t_success <= '0;
      q_r.t_try     <= '0;
    end else if (shift) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

[sv/rres_head.sv]
// ----------------------------------------------------------------------------
// rres_head
// Head of the ring: checks eligibility and applies the transaction's update.
// ----------------------------------------------------------------------------
module rres_head (
  input  rres_pkg::entry_t   cur,
  input  rres_pkg::in_item_t item,
  input  rres_pkg::head_ctl_t ctl,
  output rres_pkg::entry_t   upd,
  output logic               elig
);

  logic [31:0] now;
  logic [31:0] dif_s;
  logic [31:0] dif_t;
  logic        redo_ok;
  logic        retry_ok;
  logic        hour_ok;
  logic        day_ok;

  assign now   = item.now_seconds;
  assign dif_s = now - cur.t_success;
  assign dif_t = now - cur.t_try;

  assign redo_ok  = (cur.redo_sec == '0) ||
                    ((now >= cur.t_success) && (dif_s >= {10'd0, cur.redo_sec}));
  assign retry_ok = (cur.retry_sec == '0) ||
                    ((now >= cur.t_try) && (dif_t >= {10'd0, cur.retry_sec}));
  assign hour_ok  = (item.hour_of_day <= 5'd23) && cur.hours[item.hour_of_day];
  assign day_ok   = (item.weekday <= 3'd6) && cur.days[item.weekday];
  assign elig     = cur.valid && hour_ok && day_ok && redo_ok && retry_ok;

  always_comb begin
    upd = cur;
    if (ctl.op == rres_pkg::OP_ALL_DONE) begin
      upd.t_success = now;
      upd.t_try     = now;
    end else if (ctl.sel) begin
      case (ctl.op)
        rres_pkg::OP_LOAD: begin
          upd.valid     = 1'b1;
          upd.kind      = item.entry_kind;
          upd.hours     = item.hour_mask;
          upd.days      = item.day_mask;
          upd.redo_sec  = {item.redo_minutes, 6'd0} - {4'd0, item.redo_minutes, 2'd0};
          upd.retry_sec = {item.retry_minutes, 6'd0} - {4'd0, item.retry_minutes, 2'd0};
          upd.t_success = '0;
          upd.t_try     = '0;
        end
        rres_pkg::OP_REPORT: begin
          if (item.mark_success) upd.t_success = now;
          if (item.mark_try) upd.t_try = now;
        end
        rres_pkg::OP_ZAP: begin
          upd.valid = 1'b0;
        end
        rres_pkg::OP_RESET: begin
          upd.t_success = '0;
          upd.t_try     = '0;
        end
        rres_pkg::OP_DONE: begin
          upd.t_success = now;
          upd.t_try     = now;
        end
        default: begin
          upd = cur;
        end
      endcase
    end
  end

endmodule

[sv/round_robin_event_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// round_robin_event_scheduler_unit
// Event table held in a ring of cells that rotates once per transaction.
// Once accepted, a transaction makes one full turn of the ring (a shift per
// table entry; the last shift also loads the result register); busy meanwhile.
// No new transaction is accepted while busy; the ring length sets the rate.
// Reset: synchronous; all entries invalid, times and pointer zero, count zero.
// The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module round_robin_event_scheduler_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rres_pkg::in_item_t  in_data,
  output logic                out_strobe,
  output rres_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_wdata
);

  localparam int unsigned D = rres_pkg::TABLE_DEPTH;
  localparam int unsigned IW = rres_pkg::IDX_W;
  localparam int unsigned CW = rres_pkg::CNT_W;

  rres_pkg::entry_t    ring [D];
  rres_pkg::entry_t    upd;
  rres_pkg::in_item_t  cmd_r;
  rres_pkg::out_item_t out_r;
  rres_pkg::out_item_t out_nxt;
  rres_pkg::head_ctl_t ctl;

  logic [5:0]    cnt_cfg_r;
  logic          busy_r;
  logic          out_strobe_r;
  logic [IW-1:0] cnt_r;
  logic [CW-1:0] n_r;
  logic [CW-1:0] n_nxt;
  logic [IW-1:0] ptr_r;
  logic [IW-1:0] ptr_nxt;
  logic [IW-1:0] sp_r;
  logic          in_rng_r;
  logic          hi_f_r, lo_f_r;
  logic [IW-1:0] hi_i_r, lo_i_r;
  logic [2:0]    hi_k_r, lo_k_r;
  logic          elig;
  logic          hit, hi_hit, lo_hit;
  logic          hi_f, lo_f;
  logic [IW-1:0] hi_i, lo_i, ch_i;
  logic [2:0]    hi_k, lo_k, ch_k;
  logic [CW-1:0] ch_inc;
  logic          last;
  logic          acc;

  assign acc   = start && !busy_r;
  assign n_nxt = (cnt_cfg_r > CW'(D)) ? CW'(D) : cnt_cfg_r;
  assign last  = (cnt_r == IW'(D - 1));

  for (genvar k = 0; k < D; k++) begin : g_ring
    rres_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (busy_r),
      .d     ((k == D - 1) ? upd : ring[(k + 1) % D]),
      .q     (ring[k])
    );
  end

  assign ctl.op  = cmd_r.operation;
  assign ctl.sel = in_rng_r && (cmd_r.entry_index == cnt_r);

  rres_head u_head (
    .cur  (ring[0]),
    .item (cmd_r),
    .ctl  (ctl),
    .upd  (upd),
    .elig (elig)
  );

  assign hit    = elig && ({1'b0, cnt_r} < n_r);
  assign hi_hit = hit && (cnt_r >= sp_r) && !hi_f_r;
  assign lo_hit = hit && (cnt_r < sp_r) && !lo_f_r;
  assign hi_f   = hi_f_r || hi_hit;
  assign lo_f   = lo_f_r || lo_hit;
  assign hi_i   = hi_hit ? cnt_r : hi_i_r;
  assign lo_i   = lo_hit ? cnt_r : lo_i_r;
  assign hi_k   = hi_hit ? ring[0].kind : hi_k_r;
  assign lo_k   = lo_hit ? ring[0].kind : lo_k_r;
  assign ch_i   = hi_f ? hi_i : lo_i;
  assign ch_k   = hi_f ? hi_k : lo_k;
  assign ch_inc = {1'b0, ch_i} + CW'(1);

  always_comb begin
    out_nxt = '0;
    ptr_nxt = ptr_r;
    if (cmd_r.operation == rres_pkg::OP_POLL) begin
      if (n_r == '0) begin
        out_nxt.status = rres_pkg::ST_NONE;
      end else if (hi_f || lo_f) begin
        out_nxt.status       = rres_pkg::ST_OK;
        out_nxt.chosen_index = ch_i;
        out_nxt.chosen_kind  = ch_k;
        ptr_nxt              = (ch_inc < n_r) ? ch_inc[IW-1:0] : '0;
      end else begin
        out_nxt.status = rres_pkg::ST_NONE;
        ptr_nxt        = sp_r;
      end
    end else if (cmd_r.operation == rres_pkg::OP_ALL_DONE) begin
      out_nxt.status = rres_pkg::ST_OK;
    end else if (!in_rng_r) begin
      out_nxt.status = rres_pkg::ST_RANGE;
    end else if (cmd_r.operation == rres_pkg::OP_SET_NEXT) begin
      ptr_nxt = cmd_r.entry_index;
    end
    out_nxt.next_pointer = ptr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_cfg_r    <= '0;
      busy_r       <= 1'b0;
      out_strobe_r <= 1'b0;
      cnt_r        <= '0;
      ptr_r        <= '0;
      hi_f_r       <= 1'b0;
      lo_f_r       <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_we) cnt_cfg_r <= cfg_wdata;
      if (acc) begin
        busy_r   <= 1'b1;
        cnt_r    <= '0;
        cmd_r    <= in_data;
        n_r      <= n_nxt;
        in_rng_r <= ({1'b0, in_data.entry_index} < n_nxt);
        sp_r     <= ({1'b0, ptr_r} >= n_nxt) ? '0 : ptr_r;
        hi_f_r   <= 1'b0;
        lo_f_r   <= 1'b0;
      end else if (busy_r) begin
        cnt_r  <= cnt_r + IW'(1);
        hi_f_r <= hi_f;
        lo_f_r <= lo_f;
        hi_i_r <= hi_i;
        lo_i_r <= lo_i;
        hi_k_r <= hi_k;
        lo_k_r <= lo_k;
        if (last) begin
          busy_r       <= 1'b0;
          out_strobe_r <= 1'b1;
          out_r        <= out_nxt;
          ptr_r        <= ptr_nxt;
        end
      end
    end
  end

  assign busy       = busy_r;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  a_fell_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> out_strobe_r) else $error("busy fell without result");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> !busy_r) else $error("result while busy");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (out_r.status != 2'd3)) else $error("bad status code");
  a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !last) |=> busy_r) else $error("ring turn cut short");

endmodule

[tb/sv/tb_round_robin_event_scheduler_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_event_scheduler_unit
// Self-checking bench for the round-robin event scheduler. A queue of command
// transactions feeds a clocked driver; a clocked monitor compares each result
// strobe with a scheduler prediction kept in the bench, over several table
// sizes written between phases.
// ----------------------------------------------------------------------------
module tb_round_robin_event_scheduler_unit;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 80;
  localparam int TD = rres_pkg::TABLE_DEPTH;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  rres_pkg::in_item_t in_data;
  logic out_strobe;
  rres_pkg::out_item_t out_data;
  logic cfg_we;
  logic [5:0] cfg_wdata;

  rres_pkg::in_item_t cmd_queue[$];
  rres_pkg::out_item_t sched_results[$];

  // predicted scheduler state
  logic [5:0] tbl_count;
  logic tbl_valid[TD] = '{default: 1'b0};
  logic [2:0] tbl_kind[TD] = '{default: '0};
  logic [23:0] tbl_hours[TD] = '{default: '0};
  logic [6:0] tbl_days[TD] = '{default: '0};
  logic [15:0] tbl_redo[TD] = '{default: '0};
  logic [15:0] tbl_retry[TD] = '{default: '0};
  logic [31:0] tbl_success[TD] = '{default: '0};
  logic [31:0] tbl_try[TD] = '{default: '0};
  logic [4:0] tbl_pointer = '0;

  int error_count;
  int accepted_count;
  int checked_count;
  int chosen_count;
  int idle_cycles;
  int quiet_start;
  bit quiet_mode;

  round_robin_event_scheduler_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_strobe(out_strobe),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned minutes_since(logic [31:0] now, logic [31:0] then);
    return (now >= then) ? (now - then) / 60 : 0;
  endfunction

  function automatic bit entry_ready(int e, rres_pkg::in_item_t it);
    if (!tbl_valid[e]) return 0;
    if (it.hour_of_day > 23 || !tbl_hours[e][it.hour_of_day]) return 0;
    if (it.weekday > 6 || !tbl_days[e][it.weekday]) return 0;
    if (minutes_since(it.now_seconds, tbl_success[e]) < tbl_redo[e]) return 0;
    if (minutes_since(it.now_seconds, tbl_try[e]) < tbl_retry[e]) return 0;
    return 1;
  endfunction

  task automatic schedule_step(rres_pkg::in_item_t it);
    int n;
    int p;
    int q;
    int first;
    bit found;
    rres_pkg::out_item_t r;
    n = (tbl_count > TD) ? TD : int'(tbl_count);
    r = '0;
    if (it.operation == rres_pkg::OP_POLL) begin
      if (n == 0) begin
        r.status = rres_pkg::ST_NONE;
      end else begin
        if (tbl_pointer >= n) tbl_pointer = '0;
        first = tbl_pointer;
        p = first;
        found = 0;
        do begin
          q = (p + 1 < n) ? p + 1 : 0;
          if (entry_ready(p, it)) begin
            found = 1;
            r.chosen_index = 5'(p);
            r.chosen_kind = tbl_kind[p];
            p = q;
            break;
          end
          p = q;
        end while (p != first);
        tbl_pointer = 5'(p);
        r.status = found ? rres_pkg::ST_OK : rres_pkg::ST_NONE;
        if (found) chosen_count++;
      end
    end else if (it.operation == rres_pkg::OP_ALL_DONE) begin
      for (int i = 0; i < TD; i++) begin
        tbl_success[i] = it.now_seconds;
        tbl_try[i] = it.now_seconds;
      end
    end else if (it.entry_index >= n) begin
      r.status = rres_pkg::ST_RANGE;
    end else begin
      case (it.operation)
        rres_pkg::OP_LOAD: begin
          tbl_valid[it.entry_index] = 1'b1;
          tbl_kind[it.entry_index] = it.entry_kind;
          tbl_hours[it.entry_index] = it.hour_mask;
          tbl_days[it.entry_index] = it.day_mask;
          tbl_redo[it.entry_index] = it.redo_minutes;
          tbl_retry[it.entry_index] = it.retry_minutes;
          tbl_success[it.entry_index] = '0;
          tbl_try[it.entry_index] = '0;
        end
        rres_pkg::OP_REPORT: begin
          if (it.mark_success) tbl_success[it.entry_index] = it.now_seconds;
          if (it.mark_try) tbl_try[it.entry_index] = it.now_seconds;
        end
        rres_pkg::OP_ZAP: tbl_valid[it.entry_index] = 1'b0;
        rres_pkg::OP_RESET: begin
          tbl_success[it.entry_index] = '0;
          tbl_try[it.entry_index] = '0;
        end
        rres_pkg::OP_DONE: begin
          tbl_success[it.entry_index] = it.now_seconds;
          tbl_try[it.entry_index] = it.now_seconds;
        end
        default: tbl_pointer = it.entry_index;
      endcase
    end
    r.next_pointer = tbl_pointer;
    sched_results.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
    end else if (start && !busy) begin
      schedule_step(in_data);
      accepted_count++;
      if (cmd_queue.size() > 0 && !(quiet_mode == 0 && $urandom_range(99) < 7)) begin
        in_data <= cmd_queue.pop_front();
      end else begin
        start <= 1'b0;
      end
    end else if (!start && cmd_queue.size() > 0) begin
      if (quiet_mode || $urandom_range(99) >= 7) begin
        in_data <= cmd_queue.pop_front();
        start <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rres_pkg::out_item_t want;
    if (rst_n && out_strobe) begin
      if (sched_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        error_count++;
      end else begin
        want = sched_results.pop_front();
        checked_count++;
        if (out_data.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_data.status);
        if (out_data.chosen_index !== want.chosen_index)
          $display("%0t: chosen_index expected %0d actual %0d", $time,
                   want.chosen_index, out_data.chosen_index);
        if (out_data.chosen_kind !== want.chosen_kind)
          $display("%0t: chosen_kind expected %0d actual %0d", $time,
                   want.chosen_kind, out_data.chosen_kind);
        if (out_data.next_pointer !== want.next_pointer)
          $display("%0t: next_pointer expected %0d actual %0d", $time,
                   want.next_pointer, out_data.next_pointer);
        if (out_data !== want) error_count++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cmd_queue.size() == 0 &&
        sched_results.size() == 0 && !start) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic rres_pkg::in_item_t random_cmd(int n);
    rres_pkg::in_item_t it;
    int pick;
    it = '0;
    it.entry_kind = 3'($urandom);
    it.hour_mask = 24'($urandom);
    it.day_mask = 7'($urandom);
    it.redo_minutes = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20));
    it.retry_minutes = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20));
    it.now_seconds = ($urandom_range(7) == 0) ? $urandom : $urandom_range(4000);
    it.hour_of_day = ($urandom_range(15) == 0) ? 5'($urandom) : 5'($urandom_range(23));
    it.weekday = ($urandom_range(15) == 0) ? 3'($urandom) : 3'($urandom_range(6));
    it.mark_success = 1'($urandom);
    it.mark_try = 1'($urandom);
    if (n > 0 && $urandom_range(9) != 0) it.entry_index = 5'($urandom_range(n - 1));
    else it.entry_index = 5'($urandom);
    pick = $urandom_range(99);
    if (pick < 15) it.operation = rres_pkg::OP_LOAD;
    else if (pick < 55) it.operation = rres_pkg::OP_POLL;
    else if (pick < 70) it.operation = rres_pkg::OP_REPORT;
    else if (pick < 75) it.operation = rres_pkg::OP_ZAP;
    else if (pick < 82) it.operation = rres_pkg::OP_RESET;
    else if (pick < 89) it.operation = rres_pkg::OP_DONE;
    else if (pick < 93) it.operation = rres_pkg::OP_ALL_DONE;
    else it.operation = rres_pkg::OP_SET_NEXT;
    return it;
  endfunction

  task automatic wait_drained();
    while (cmd_queue.size() > 0 || start || sched_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_count(logic [5:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tbl_count = value;
  endtask

  initial begin
    rres_pkg::in_item_t it;
    int n;
    logic [5:0] sizes[6];
    sizes = '{6'd32, 6'd1, 6'd5, 6'd63, 6'd17, 6'd0};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    quiet_mode = 0;
    tbl_count = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, then full table with extremes
    it = '0;
    it.operation = rres_pkg::OP_POLL;
    cmd_queue.push_back(it);
    it.operation = rres_pkg::OP_LOAD;
    cmd_queue.push_back(it);
    wait_drained();
    write_count(6'd32);
    it = '0;
    it.operation = rres_pkg::OP_LOAD;
    it.entry_index = 5'd31;
    it.entry_kind = 3'd7;
    it.hour_mask = 24'hFFFFFF;
    it.day_mask = 7'h7F;
    cmd_queue.push_back(it);
    it.entry_index = 5'd0;
    it.entry_kind = 3'd3;
    it.redo_minutes = 16'hFFFF;
    it.retry_minutes = 16'hFFFF;
    cmd_queue.push_back(it);
    it = '0;
    it.operation = rres_pkg::OP_POLL;
    it.hour_of_day = 5'd23;
    it.weekday = 3'd6;
    cmd_queue.push_back(it);
    cmd_queue.push_back(it);
    it.hour_of_day = 5'd31;
    cmd_queue.push_back(it);
    it.hour_of_day = 5'd0;
    it.weekday = 3'd7;
    cmd_queue.push_back(it);
    it.weekday = 3'd0;
    it.now_seconds = 32'hFFFFFFFF;
    cmd_queue.push_back(it);
    it = '0;
    it.operation = rres_pkg::OP_REPORT;
    it.entry_index = 5'd31;
    it.mark_success = 1'b1;
    it.mark_try = 1'b1;
    it.now_seconds = 32'hFFFFFFFF;
    cmd_queue.push_back(it);
    it.operation = rres_pkg::OP_POLL;
    it.now_seconds = 32'd100;
    cmd_queue.push_back(it);
    it.operation = rres_pkg::OP_DONE;
    cmd_queue.push_back(it);
    it.operation = rres_pkg::OP_RESET;
    cmd_queue.push_back(it);
    it.operation = rres_pkg::OP_ZAP;
    cmd_queue.push_back(it);
    it.operation = rres_pkg::OP_ALL_DONE;
    it.now_seconds = 32'd7;
    cmd_queue.push_back(it);
    it.operation = rres_pkg::OP_SET_NEXT;
    it.entry_index = 5'd30;
    cmd_queue.push_back(it);
    it.operation = rres_pkg::OP_POLL;
    cmd_queue.push_back(it);
    wait_drained();
    write_count(6'd4);
    it = '0;
    it.operation = rres_pkg::OP_POLL;
    cmd_queue.push_back(it);
    it.operation = rres_pkg::OP_SET_NEXT;
    it.entry_index = 5'd4;
    cmd_queue.push_back(it);
    it.operation = rres_pkg::OP_LOAD;
    cmd_queue.push_back(it);
    wait_drained();

    // random phases over several table sizes
    foreach (sizes[s]) begin
      write_count(sizes[s]);
      n = (sizes[s] > TD) ? TD : int'(sizes[s]);
      for (int i = 0; i < n; i++) begin
        it = random_cmd(n);
        it.operation = rres_pkg::OP_LOAD;
        it.entry_index = 5'(i);
        it.redo_minutes = 16'($urandom_range(5));
        it.retry_minutes = 16'($urandom_range(5));
        cmd_queue.push_back(it);
      end
      for (int k = 0; k < 200; k++) cmd_queue.push_back(random_cmd(n));
      quiet_start = $urandom_range(150);
      while (cmd_queue.size() > 0 || start || sched_results.size() > 0) begin
        @(posedge clk);
        quiet_mode = (cmd_queue.size() < 200 - quiet_start + 30 &&
                      cmd_queue.size() > 200 - quiet_start - 30);
      end
      quiet_mode = 0;
      repeat (40) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d transactions, %0d results checked, %0d polls chose an entry",
             accepted_count, checked_count, chosen_count);
    $display("table sizes 0, 1, 4, 5, 17, 32 and over-range 63 were exercised");
    if (error_count == 0 && sched_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
